// ----- src/sfc_pkg.sv -----
// Shared constants and types for the sensor frame checker.
package sfc_pkg;

  // Frame layout constants.
  localparam logic [7:0] FrameHead = 8'h77;
  localparam logic [7:0] MinLength = 8'd4;

  // Configuration register indexes.
  localparam logic [1:0] CfgDeviceAddress  = 2'd0;
  localparam logic [1:0] CfgExpectedCmd    = 2'd1;
  localparam logic [1:0] CfgCmdCheckEnable = 2'd2;

  // Frame status codes reported on the last beat of a frame.
  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StBadHeader   = 2'd1,
    StBadChecksum = 2'd2,
    StBadLength   = 2'd3
  } sfc_status_e;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] expected_command;
    logic       command_check_enable;
  } sfc_cfg_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  byte_echo;
    logic        is_payload;
    logic [7:0]  payload_index;
    logic        frame_end;
    sfc_status_e frame_status;
    logic        address_mismatch;
    logic        command_mismatch;
    logic [7:0]  command_code;
  } sfc_result_t;

endpackage

// ----- src/sfc_parser.sv -----
// Frame parser: phase machine, running checksum and the result register.
module sfc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          rx_byte_i,
  input  sfc_pkg::sfc_cfg_t   cfg_i,
  output sfc_pkg::sfc_result_t result_o
);
  import sfc_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhLen,
    PhAddr,
    PhCmd,
    PhData,
    PhSum
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  length_q, length_d;
  logic [7:0]  position_q, position_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  command_q, command_d;
  logic        addr_warn_q, addr_warn_d;
  logic        cmd_warn_q, cmd_warn_d;
  sfc_result_t result_q, result_d;

  logic [7:0]  sum_add;
  logic        stray;

  assign sum_add = sum_q + rx_byte_i;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    position_d  = position_q;
    sum_d       = sum_q;
    command_d   = command_q;
    addr_warn_d = addr_warn_q;
    cmd_warn_d  = cmd_warn_q;
    stray       = 1'b0;

    result_d               = '0;
    result_d.byte_echo     = rx_byte_i;
    result_d.frame_status  = StOk;

    unique case (phase_q)
      PhLen: begin
        length_d = rx_byte_i;
        if (rx_byte_i < MinLength) begin
          result_d.frame_end    = 1'b1;
          result_d.frame_status = StBadLength;
          phase_d               = PhIdle;
        end else begin
          sum_d   = rx_byte_i;
          phase_d = PhAddr;
        end
      end
      PhAddr: begin
        sum_d       = sum_add;
        addr_warn_d = (rx_byte_i != cfg_i.device_address);
        phase_d     = PhCmd;
      end
      PhCmd: begin
        sum_d      = sum_add;
        command_d  = rx_byte_i;
        cmd_warn_d = cfg_i.command_check_enable && (rx_byte_i != cfg_i.expected_command);
        position_d = MinLength;
        phase_d    = (length_q == MinLength) ? PhSum : PhData;
      end
      PhData: begin
        result_d.is_payload    = 1'b1;
        result_d.payload_index = position_q - MinLength;
        sum_d                  = sum_add;
        position_d             = position_q + 8'd1;
        if (position_d >= length_q) begin
          phase_d = PhSum;
        end
      end
      PhSum: begin
        result_d.frame_end    = 1'b1;
        result_d.frame_status = (rx_byte_i == sum_q) ? StOk : StBadChecksum;
        phase_d               = PhIdle;
      end
      default: begin
        if (rx_byte_i == FrameHead) begin
          length_d    = '0;
          position_d  = '0;
          sum_d       = '0;
          command_d   = '0;
          addr_warn_d = 1'b0;
          cmd_warn_d  = 1'b0;
          phase_d     = PhLen;
        end else begin
          stray                 = 1'b1;
          result_d.frame_end    = 1'b1;
          result_d.frame_status = StBadHeader;
        end
      end
    endcase

    // Warnings and command code follow the updated frame state.
    result_d.address_mismatch = addr_warn_d && !stray;
    result_d.command_mismatch = cmd_warn_d && !stray;
    result_d.command_code     = stray ? 8'd0 : command_d;
  end

  // State and result register, updated once per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      length_q    <= '0;
      position_q  <= '0;
      sum_q       <= '0;
      command_q   <= '0;
      addr_warn_q <= 1'b0;
      cmd_warn_q  <= 1'b0;
      result_q    <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      length_q    <= length_d;
      position_q  <= position_d;
      sum_q       <= sum_d;
      command_q   <= command_d;
      addr_warn_q <= addr_warn_d;
      cmd_warn_q  <= cmd_warn_d;
      result_q    <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- src/sensor_frame_checker_unit.sv -----
// Top level of the sensor frame checker: handshakes, configuration, parser.
//
//  Channel  Direction  Handshake                  Payload
//  rx       in         rx_valid_i / rx_stall_o    rx_byte_i
//  out      out        out_valid_o / out_stall_i  byte_echo_o .. command_code_o
//  cfg      in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// Every byte taken gives one result beat: the byte waits in the input register,
// then the parser updates its state and the result register.
// One byte per cycle is sustained while the output is not stalled.
// Reset clears the configuration registers, the parse phase and both valid flags.
// A stall on the output holds the result register; a byte may still be taken
// into the empty input register, and rx_stall_o rises only when both are full.
module sensor_frame_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_echo_o,
  output logic       is_payload_o,
  output logic [7:0] payload_index_o,
  output logic       frame_end_o,
  output logic [1:0] frame_status_o,
  output logic       address_mismatch_o,
  output logic       command_mismatch_o,
  output logic [7:0] command_code_o
);
  import sfc_pkg::*;

  sfc_cfg_t    cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic        advance;
  logic        rx_accept;
  sfc_result_t result;

  // The parser moves a beat when the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign rx_stall_o = in_valid_q && !advance;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDeviceAddress:  cfg_q.device_address       <= cfg_data_i;
        CfgExpectedCmd:    cfg_q.expected_command     <= cfg_data_i;
        CfgCmdCheckEnable: cfg_q.command_check_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register and valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_byte_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_accept) begin
        in_valid_q <= 1'b1;
        in_byte_q  <= rx_byte_i;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  sfc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  assign out_valid_o        = out_valid_q;
  assign byte_echo_o        = result.byte_echo;
  assign is_payload_o       = result.is_payload;
  assign payload_index_o    = result.payload_index;
  assign frame_end_o        = result.frame_end;
  assign frame_status_o     = result.frame_status;
  assign address_mismatch_o = result.address_mismatch;
  assign command_mismatch_o = result.command_mismatch;
  assign command_code_o     = result.command_code;

  // The input side is held back only by a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled without output back-pressure");

  // A status other than ok only appears on the last beat of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_end_o) |-> (frame_status_o == StOk))
    else $error("status reported on a beat that does not end a frame");

  // Payload beats never end a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_payload_o) |-> !frame_end_o)
    else $error("payload beat marked as frame end");

  // A stray byte carries no frame warnings or command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o == StBadHeader) |->
      (!address_mismatch_o && !command_mismatch_o && command_code_o == 8'd0))
    else $error("bad header beat carries frame information");

endmodule
